// ===== sv/hmac_pkg.sv =====
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine package
// Payload types, SHA-1 constants and byte helpers shared by the engine and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package hmac_pkg;

    typedef struct packed {
        logic       opcode;
        logic       has_byte;
        logic [7:0] data_byte;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [31:0] tag_word;
        logic        word_last;
    } tag_t;

    localparam logic OP_KEY = 1'b0;
    localparam logic OP_MSG = 1'b1;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5c;
    localparam logic [7:0] MARK_BYTE = 8'h80;

    localparam int unsigned BLOCK_BYTES  = 64;
    localparam int unsigned DIGEST_BYTES = 20;

    // Bit length of the outer message: one pad block plus the inner digest.
    localparam logic [63:0] OUTER_BITS = 64'd672;

    localparam logic [159:0] SHA_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                       32'h10325476, 32'hC3D2E1F0};

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Byte i (0 first) of a 160-bit digest, big-endian.
    function automatic logic [7:0] digest_byte(input logic [159:0] d, input logic [4:0] i);
        logic [7:0] r;
        r = d[8'd159 - {i, 3'b000} -: 8];
        return r;
    endfunction

    // Byte j (0 first) of a 64-bit big-endian length field.
    function automatic logic [7:0] length_byte(input logic [63:0] v, input logic [2:0] j);
        logic [7:0] r;
        r = v[6'd63 - {j, 3'b000} -: 8];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/hmac_sha1_engine_unit.sv =====
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine
// Streams key and message bytes and returns the 160-bit HMAC-SHA1 tag.
// ----------------------------------------------------------------------------
// Bytes are accepted only while the engine is idle. Each SHA-1 block compression
// streams the block from a byte memory into the schedule register, runs 80
// rounds and then adds into the chain, with the item channel stalled throughout.
// The final message item costs three or four compressions before the five tag
// words appear, one per cycle while not stalled. Reset is asynchronous and
// returns the engine to awaiting a new key.
`default_nettype none

module hmac_sha1_engine_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire hmac_pkg::item_t item,
    output logic                tag_valid,
    input  wire logic           tag_stall,
    output hmac_pkg::tag_t      tag
);

    // Top-level sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // Compression jobs. Each names where the 64 bytes of a block come from.
    localparam logic [2:0] J_KEYRAW = 3'd0; // long key: first 64 key bytes
    localparam logic [2:0] J_FULL   = 3'd1; // a full block from the buffer
    localparam logic [2:0] J_FIN1   = 3'd2; // buffered tail with padding
    localparam logic [2:0] J_FIN2   = 3'd3; // extra block holding the length only
    localparam logic [2:0] J_IPAD   = 3'd4; // key XOR inner pad
    localparam logic [2:0] J_OPAD   = 3'd5; // key XOR outer pad
    localparam logic [2:0] J_OUTER  = 3'd6; // inner digest with padding

    localparam logic PH_KEY = 1'b0;
    localparam logic PH_MSG = 1'b1;

    // Control registers.
    logic [2:0]   state_reg, state_next;
    logic [2:0]   job_reg, job_next;
    logic         phase_reg, phase_next;
    logic         fin_pend_reg, fin_pend_next;
    logic         keydig_reg, keydig_next;
    logic [63:0]  kc_reg, kc_next;
    logic [63:0]  mbc_reg, mbc_next;
    logic [6:0]   ld_cnt_reg, ld_cnt_next;
    logic         rdv_reg, rdv_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic [2:0]   out_cnt_reg, out_cnt_next;

    // Datapath registers.
    logic [159:0] chain_reg, chain_next;
    logic [159:0] work_reg, work_next;
    logic [511:0] w_reg, w_next;
    logic [159:0] keyd_reg, keyd_next;
    logic [159:0] inner_reg, inner_next;
    logic [5:0]   fin_n_reg, fin_n_next;
    logic [63:0]  len_reg, len_next;
    logic [5:0]   idx_q_reg;

    // Byte memories: the key pad store and the block buffer.
    localparam int unsigned BLOCK_BYTES_L = hmac_pkg::BLOCK_BYTES;
    logic [7:0]   key_mem [BLOCK_BYTES_L];
    logic [7:0]   buf_mem [BLOCK_BYTES_L];
    logic         key_we, buf_we;
    logic [5:0]   wr_addr;
    logic [7:0]   key_q, buf_q;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= item.data_byte;
        end
        if (buf_we)
        begin
            buf_mem[wr_addr] <= item.data_byte;
        end
        key_q     <= key_mem[ld_cnt_reg[5:0]];
        buf_q     <= buf_mem[ld_cnt_reg[5:0]];
        idx_q_reg <= ld_cnt_reg[5:0];
    end

    // Byte assembly for the block that is being loaded. Bytes of the key
    // beyond the key count read as zero, which stands in for clearing the
    // pad store; the padding marker and length are inserted here rather
    // than written into the buffer.
    logic [7:0]  key_byte, blk_byte;
    logic [7:0]  pad_xor;
    logic [6:0]  n_val;
    logic        mark_en, len_en;
    logic [63:0] len_val;

    always_comb
    begin
        pad_xor = 8'h00;
        n_val   = 7'd64;
        mark_en = 1'b0;
        len_en  = 1'b0;
        len_val = len_reg;
        case (job_reg)
            J_IPAD:  pad_xor = hmac_pkg::IPAD_BYTE;
            J_OPAD:  pad_xor = hmac_pkg::OPAD_BYTE;
            J_FIN1:
            begin
                n_val   = {1'b0, fin_n_reg};
                mark_en = 1'b1;
                len_en  = (fin_n_reg < 6'd56);
            end
            J_FIN2:
            begin
                n_val  = 7'd0;
                len_en = 1'b1;
            end
            J_OUTER:
            begin
                n_val   = 7'd20;
                mark_en = 1'b1;
                len_en  = 1'b1;
                len_val = hmac_pkg::OUTER_BITS;
            end
            default: ;
        endcase

        if (keydig_reg)
        begin
            key_byte = (idx_q_reg < 6'd20) ?
                       hmac_pkg::digest_byte(keyd_reg, idx_q_reg[4:0]) : 8'h00;
        end
        else
        begin
            key_byte = (kc_reg > {58'd0, idx_q_reg}) ? key_q : 8'h00;
        end

        case (job_reg)
            J_KEYRAW, J_IPAD, J_OPAD: blk_byte = key_byte ^ pad_xor;
            J_OUTER:
                blk_byte = (idx_q_reg < 6'd20) ?
                           hmac_pkg::digest_byte(inner_reg, idx_q_reg[4:0]) : 8'h00;
            default:
                blk_byte = ({1'b0, idx_q_reg} < n_val) ? buf_q : 8'h00;
        endcase
        if (mark_en && ({1'b0, idx_q_reg} == n_val))
        begin
            blk_byte = hmac_pkg::MARK_BYTE;
        end
        if (len_en && (idx_q_reg >= 6'd56))
        begin
            blk_byte = hmac_pkg::length_byte(len_val, idx_q_reg[2:0]);
        end
    end

    // One SHA-1 round on the working variables. The schedule register holds
    // sixteen words with the current word at the top.
    logic [31:0] a, b, c, d, e, f, k, t, w0, w_new;

    always_comb
    begin
        a  = work_reg[159:128];
        b  = work_reg[127:96];
        c  = work_reg[95:64];
        d  = work_reg[63:32];
        e  = work_reg[31:0];
        w0 = w_reg[511:480];
        w_new = w_reg[95:64] ^ w_reg[255:224] ^ w_reg[447:416] ^ w0;
        w_new = {w_new[30:0], w_new[31]};
        if (rnd_reg < 7'd20)
        begin
            f = (b & c) | (~b & d);
            k = hmac_pkg::K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b ^ c ^ d;
            k = hmac_pkg::K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b & c) | (b & d) | (c & d);
            k = hmac_pkg::K2;
        end
        else
        begin
            f = b ^ c ^ d;
            k = hmac_pkg::K3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w0;
    end

    logic [159:0] chain_sum;

    always_comb
    begin
        chain_sum = {chain_reg[159:128] + work_reg[159:128],
                     chain_reg[127:96]  + work_reg[127:96],
                     chain_reg[95:64]   + work_reg[95:64],
                     chain_reg[63:32]   + work_reg[63:32],
                     chain_reg[31:0]    + work_reg[31:0]};
    end

    // Handshakes.
    logic accept, tag_take;
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign tag_valid  = (state_reg == ST_OUT);
    assign tag_take   = tag_valid && !tag_stall;

    always_comb
    begin
        tag.tag_word  = chain_reg[8'd159 - {out_cnt_reg, 5'b00000} -: 32];
        tag.word_last = (out_cnt_reg == 3'd4);
    end

    // Sequencer.
    logic [63:0] kc_inc, mbc_inc;

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        phase_next    = phase_reg;
        fin_pend_next = fin_pend_reg;
        keydig_next   = keydig_reg;
        kc_next       = kc_reg;
        mbc_next      = mbc_reg;
        ld_cnt_next   = ld_cnt_reg;
        rdv_next      = 1'b0;
        rnd_next      = rnd_reg;
        out_cnt_next  = out_cnt_reg;
        chain_next    = chain_reg;
        work_next     = work_reg;
        w_next        = w_reg;
        keyd_next     = keyd_reg;
        inner_next    = inner_reg;
        fin_n_next    = fin_n_reg;
        len_next      = len_reg;
        key_we        = 1'b0;
        buf_we        = 1'b0;
        wr_addr       = 6'd0;
        kc_inc        = kc_reg + 64'd1;
        mbc_inc       = mbc_reg + 64'd8;

        case (state_reg)
            ST_IDLE:
            begin
                ld_cnt_next = 7'd0;
                if (accept && (phase_reg == PH_KEY) && (item.opcode == hmac_pkg::OP_KEY))
                begin
                    wr_addr = kc_reg[5:0];
                    if (item.has_byte)
                    begin
                        kc_next = kc_inc;
                        if (kc_reg < 64'd64)
                        begin
                            key_we = 1'b1;
                        end
                        else
                        begin
                            buf_we = 1'b1;
                        end
                    end
                    fin_pend_next = item.last && (kc_next > 64'd64);
                    fin_n_next    = kc_next[5:0];
                    len_next      = {kc_next[60:0], 3'b000};
                    if (item.has_byte && (kc_reg == 64'd64))
                    begin
                        job_next   = J_KEYRAW;
                        state_next = ST_LOAD;
                    end
                    else if (item.has_byte && (kc_reg > 64'd64) && (kc_reg[5:0] == 6'd63))
                    begin
                        job_next   = J_FULL;
                        state_next = ST_LOAD;
                    end
                    else if (item.last && (kc_next > 64'd64))
                    begin
                        job_next   = J_FIN1;
                        state_next = ST_LOAD;
                    end
                    else if (item.last)
                    begin
                        // A short key: the chain still holds the initial value.
                        job_next   = J_IPAD;
                        state_next = ST_LOAD;
                    end
                end
                else if (accept && (phase_reg == PH_MSG) &&
                         (item.opcode == hmac_pkg::OP_MSG))
                begin
                    wr_addr = mbc_reg[8:3];
                    if (item.has_byte)
                    begin
                        buf_we   = 1'b1;
                        mbc_next = mbc_inc;
                    end
                    fin_pend_next = item.last;
                    fin_n_next    = mbc_next[8:3];
                    len_next      = mbc_next;
                    if (item.has_byte && (mbc_reg[8:3] == 6'd63))
                    begin
                        job_next   = J_FULL;
                        state_next = ST_LOAD;
                    end
                    else if (item.last)
                    begin
                        job_next   = J_FIN1;
                        state_next = ST_LOAD;
                    end
                end
            end

            ST_LOAD:
            begin
                if (ld_cnt_reg != 7'd64)
                begin
                    ld_cnt_next = ld_cnt_reg + 7'd1;
                    rdv_next    = 1'b1;
                end
                if (rdv_reg)
                begin
                    w_next = {w_reg[503:0], blk_byte};
                end
                if (ld_cnt_reg == 7'd64)
                begin
                    work_next  = chain_reg;
                    rnd_next   = 7'd0;
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                work_next = {t, a, {b[1:0], b[31:2]}, c, d};
                w_next    = {w_reg[479:0], w_new};
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == 7'd79)
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                chain_next  = chain_sum;
                ld_cnt_next = 7'd0;
                state_next  = ST_LOAD;
                case (job_reg)
                    J_KEYRAW, J_FULL:
                    begin
                        if (fin_pend_reg)
                        begin
                            job_next = J_FIN1;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    J_FIN1, J_FIN2:
                    begin
                        if ((job_reg == J_FIN1) && (fin_n_reg >= 6'd56))
                        begin
                            job_next = J_FIN2;
                        end
                        else if (phase_reg == PH_KEY)
                        begin
                            // The key digest takes the place of the key in the pad store.
                            keyd_next   = chain_sum;
                            keydig_next = 1'b1;
                            chain_next  = hmac_pkg::SHA_IV;
                            job_next    = J_IPAD;
                        end
                        else
                        begin
                            inner_next = chain_sum;
                            chain_next = hmac_pkg::SHA_IV;
                            job_next   = J_OPAD;
                        end
                    end
                    J_IPAD:
                    begin
                        phase_next = PH_MSG;
                        mbc_next   = 64'd512;
                        state_next = ST_IDLE;
                    end
                    J_OPAD:
                    begin
                        job_next = J_OUTER;
                    end
                    default:
                    begin
                        out_cnt_next = 3'd0;
                        state_next   = ST_OUT;
                    end
                endcase
            end

            ST_OUT:
            begin
                if (tag_take)
                begin
                    out_cnt_next = out_cnt_reg + 3'd1;
                    if (out_cnt_reg == 3'd4)
                    begin
                        state_next  = ST_IDLE;
                        phase_next  = PH_KEY;
                        kc_next     = 64'd0;
                        mbc_next    = 64'd0;
                        keydig_next = 1'b0;
                        chain_next  = hmac_pkg::SHA_IV;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            job_reg      <= J_KEYRAW;
            phase_reg    <= PH_KEY;
            fin_pend_reg <= 1'b0;
            keydig_reg   <= 1'b0;
            kc_reg       <= 64'd0;
            mbc_reg      <= 64'd0;
            ld_cnt_reg   <= 7'd0;
            rdv_reg      <= 1'b0;
            rnd_reg      <= 7'd0;
            out_cnt_reg  <= 3'd0;
            chain_reg    <= hmac_pkg::SHA_IV;
        end
        else
        begin
            state_reg    <= state_next;
            job_reg      <= job_next;
            phase_reg    <= phase_next;
            fin_pend_reg <= fin_pend_next;
            keydig_reg   <= keydig_next;
            kc_reg       <= kc_next;
            mbc_reg      <= mbc_next;
            ld_cnt_reg   <= ld_cnt_next;
            rdv_reg      <= rdv_next;
            rnd_reg      <= rnd_next;
            out_cnt_reg  <= out_cnt_next;
            chain_reg    <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        w_reg     <= w_next;
        keyd_reg  <= keyd_next;
        inner_reg <= inner_next;
        fin_n_reg <= fin_n_next;
        len_reg   <= len_next;
    end

endmodule

`default_nettype wire

// ===== tb/hmac_sha1_tag_checker.sv =====
// ----------------------------------------------------------------------------
// HMAC-SHA1 tag checker
// Watches the item and tag channels, keeps its own HMAC-SHA1 state, works out
// the tag words each accepted transfer causes and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module hmac_sha1_tag_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire logic            item_stall,
    input  wire hmac_pkg::item_t item,
    input  wire logic            tag_valid,
    input  wire logic            tag_stall,
    input  wire hmac_pkg::tag_t  tag,
    output int                   errors,
    output int                   pending
);
    import hmac_pkg::*;

    typedef enum logic {AWAIT_KEY, AWAIT_MSG} phase_t;

    logic [7:0]  pad_key [64];
    logic [7:0]  blk_buf [64];
    logic [31:0] chain [5];
    logic [63:0] key_bytes;
    logic [63:0] msg_bits;
    phase_t      phase;
    tag_t        tag_q [$];

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic sha_block(input logic [7:0] b [64]);
        logic [31:0] w [80];
        logic [31:0] a, bb, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain[0]; bb = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (bb & c) | (~bb & d); k = K0;
            end
            else if (i < 40)
            begin
                f = bb ^ c ^ d; k = K1;
            end
            else if (i < 60)
            begin
                f = (bb & c) | (bb & d) | (c & d); k = K2;
            end
            else
            begin
                f = bb ^ c ^ d; k = K3;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(bb, 30); bb = a; a = t;
        end
        chain[0] += a; chain[1] += bb; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    // Appends the 0x80 marker and the length after n buffered bytes.
    task automatic sha_finish(input int n, input logic [63:0] bits);
        blk_buf[n] = MARK_BYTE;
        for (int i = n + 1; i < 64; i++) blk_buf[i] = 8'h00;
        if (n >= 56)
        begin
            sha_block(blk_buf);
            for (int i = 0; i < 56; i++) blk_buf[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) blk_buf[56+i] = bits[63-8*i -: 8];
        sha_block(blk_buf);
    endtask

    task automatic start_pad(input logic [7:0] pad);
        logic [7:0] b [64];
        for (int i = 0; i < 5; i++) chain[i] = SHA_IV[159-32*i -: 32];
        for (int i = 0; i < 64; i++) b[i] = pad_key[i] ^ pad;
        sha_block(b);
    endtask

    task automatic clear_state();
        for (int i = 0; i < 64; i++)
        begin
            pad_key[i] = 8'h00;
            blk_buf[i] = 8'h00;
        end
        for (int i = 0; i < 5; i++) chain[i] = SHA_IV[159-32*i -: 32];
        key_bytes = '0;
        msg_bits  = '0;
        phase     = AWAIT_KEY;
    endtask

    task automatic predict_tag(input item_t it);
        logic [7:0] inner [20];
        int idx;
        if (phase == AWAIT_KEY)
        begin
            if (it.opcode != OP_KEY) return;
            if (it.has_byte)
            begin
                if (key_bytes < 64)
                    pad_key[key_bytes[5:0]] = it.data_byte;
                else
                begin
                    idx = key_bytes[5:0];
                    if (key_bytes == 64) sha_block(pad_key);
                    blk_buf[idx] = it.data_byte;
                    if (idx == 63) sha_block(blk_buf);
                end
                key_bytes++;
            end
            if (!it.last) return;
            if (key_bytes > 64)
            begin
                sha_finish(key_bytes[5:0], key_bytes << 3);
                for (int i = 0; i < 64; i++) pad_key[i] = 8'h00;
                for (int i = 0; i < 20; i++)
                    pad_key[i] = chain[i/4][31-8*(i%4) -: 8];
            end
            start_pad(IPAD_BYTE);
            msg_bits = 64'd512;
            phase = AWAIT_MSG;
            return;
        end
        if (it.opcode != OP_MSG) return;
        if (it.has_byte)
        begin
            idx = msg_bits[8:3];
            blk_buf[idx] = it.data_byte;
            msg_bits += 8;
            if (idx == 63) sha_block(blk_buf);
        end
        if (!it.last) return;
        sha_finish(msg_bits[8:3], msg_bits);
        for (int i = 0; i < 20; i++) inner[i] = chain[i/4][31-8*(i%4) -: 8];
        start_pad(OPAD_BYTE);
        for (int i = 0; i < 20; i++) blk_buf[i] = inner[i];
        sha_finish(DIGEST_BYTES, OUTER_BITS);
        for (int i = 0; i < 5; i++) tag_q.push_back('{chain[i], i == 4});
        clear_state();
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
        clear_state();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tag_valid && !tag_stall)
            begin
                if (tag_q.size() == 0)
                begin
                    $display("%0t: unexpected tag word, actual %h/%b", $time,
                             tag.tag_word, tag.word_last);
                    errors++;
                end
                else
                begin
                    tag_t want;
                    want = tag_q.pop_front();
                    if (want.tag_word !== tag.tag_word || want.word_last !== tag.word_last)
                    begin
                        $display("%0t: tag mismatch, expected %h/%b actual %h/%b", $time,
                                 want.tag_word, want.word_last, tag.tag_word, tag.word_last);
                        errors++;
                    end
                end
            end
            if (item_valid && !item_stall)
                predict_tag(item);
            pending = tag_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_hmac_sha1_engine_unit.sv =====
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine testbench
// Drives keys and messages of assorted lengths through the engine under
// random idling on both channels; a separate checker predicts each tag.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hmac_sha1_engine_unit;
    import hmac_pkg::*;

    logic  clk;
    logic  rst_n;
    logic  item_valid;
    logic  item_stall;
    item_t item;
    logic  tag_valid;
    logic  tag_stall;
    tag_t  tag;
    int    errors;
    int    pending;
    int    sent;
    int    send_idle_pct;
    int    recv_idle_pct;
    longint cycles;

    hmac_sha1_engine_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .tag_valid  (tag_valid),
        .tag_stall  (tag_stall),
        .tag        (tag)
    );

    hmac_sha1_tag_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .tag_valid  (tag_valid),
        .tag_stall  (tag_stall),
        .tag        (tag),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver stalls at random on every falling edge, at the rate of the
    // current phase, so stalls can land on any word of the tag output.
    always @(negedge clk)
        tag_stall <= ($urandom_range(99) < recv_idle_pct);

    // Timeout: allows for many compressions per item and heavy stalling.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("[hmac_sha1_engine_unit] ERROR");
            $finish;
        end
    end

    // One transfer: present the item on a falling edge, optionally after an
    // idle gap, and hold it until a rising edge sees no stall. Valid stays
    // high until the next item or idle cycle replaces it.
    task automatic send_item(input logic op, input logic has, input logic [7:0] b,
                             input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{op, has, b, lst};
        @(posedge clk);
        while (item_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // A key of n bytes; with empty set the key ends on an item without a byte.
    task automatic send_key(input int n, input logic empty_end);
        for (int i = 0; i < n; i++)
            send_item(OP_KEY, 1'b1, 8'($urandom), (i == n - 1) && !empty_end);
        if (empty_end || n == 0) send_item(OP_KEY, 1'b0, 8'($urandom), 1'b1);
    endtask

    task automatic send_msg(input int n, input logic empty_end);
        for (int i = 0; i < n; i++)
            send_item(OP_MSG, 1'b1, 8'($urandom), (i == n - 1) && !empty_end);
        if (empty_end || n == 0) send_item(OP_MSG, 1'b0, 8'($urandom), 1'b1);
    endtask

    task automatic random_frame();
        int kl, ml, r;
        r  = $urandom_range(99);
        kl = (r < 10) ? $urandom_range(65, 140) : $urandom_range(0, 24);
        ml = (r > 90) ? $urandom_range(50, 130) : $urandom_range(0, 20);
        // Wrong-kind items and byte-less items are mixed in as noise.
        if ($urandom_range(9) == 0) send_item(OP_MSG, 1'($urandom), 8'($urandom), 1'($urandom));
        send_key(kl, $urandom_range(4) == 0);
        if ($urandom_range(9) == 0) send_item(OP_KEY, 1'($urandom), 8'($urandom), 1'($urandom));
        if ($urandom_range(9) == 0) send_item(OP_MSG, 1'b0, 8'($urandom), 1'b0);
        send_msg(ml, $urandom_range(4) == 0);
    endtask

    initial
    begin
        cycles        = 0;
        sent          = 0;
        send_idle_pct = 6;
        recv_idle_pct = 56;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        tag_stall     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty key and message, extreme byte values, a key of
        // exactly one block and a message that just fits the length.
        send_key(0, 1'b1);
        send_msg(0, 1'b1);
        send_item(OP_MSG, 1'b1, 8'hff, 1'b1);     // ignored while awaiting key
        send_item(OP_KEY, 1'b1, 8'h00, 1'b0);
        send_item(OP_KEY, 1'b1, 8'hff, 1'b1);
        send_item(OP_KEY, 1'b1, 8'h55, 1'b1);     // ignored while awaiting message
        send_item(OP_MSG, 1'b1, 8'hff, 0);
        send_item(OP_MSG, 1'b1, 8'h00, 1'b1);
        send_key(64, 1'b0);
        send_msg(55, 1'b0);
        while (sent < 150) random_frame();

        // A key just over a block and a length pushed into an extra block.
        send_idle_pct = 56;
        recv_idle_pct = 6;
        send_key(65, 1'b0);
        send_msg(56, 1'b1);
        while (sent < 260) random_frame();

        // A message that fills a block exactly.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_key(3, 1'b0);
        send_msg(64, 1'b0);
        while (sent < 320) random_frame();
        item_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (700) @(posedge clk);
        if (errors == 0)
            $display("[hmac_sha1_engine_unit] OK");
        else
            $display("[hmac_sha1_engine_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/hmac_pkg.sv
sv/hmac_sha1_engine_unit.sv
tb/hmac_sha1_tag_checker.sv
tb/tb_hmac_sha1_engine_unit.sv
